// File: rtl/core/knn_pkg.sv
// Shared constants and types of the nearest-neighbor digit classifier.
// Used by the neighbor cell, the cell chain and the top level.
package knn_pkg;

    localparam int MAX_NEIGHBORS     = 16;
    localparam int MAX_VECTOR_LENGTH = 1024;
    localparam int CLASS_COUNT       = 10;

    localparam int PIXEL_W = 8;
    localparam int LABEL_W = 4;
    localparam int K_W     = 5;
    localparam int DIST_W  = 27;
    localparam int SQ_W    = 2 * PIXEL_W;
    localparam int IDX_W   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int HELD_W  = $clog2(MAX_NEIGHBORS + 1);
    localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
    localparam int CLS_W   = $clog2(CLASS_COUNT);

    localparam logic [K_W-1:0]    K_RESET  = K_W'(3);
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic                                valid;
        logic [DIST_W-1:0]                   max_d;
        logic [IDX_W-1:0]                    max_pos;
        logic [CLASS_COUNT-1:0][CNT_W-1:0]   votes;
    } scan_tok_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic [DIST_W-1:0]   distance;
        logic [LABEL_W-1:0]  label;
    } cell_wr_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_PLACE,
        ST_LAUNCH,
        ST_SCAN,
        ST_PICK,
        ST_EMIT
    } knn_state_t;

endpackage

// File: rtl/core/knn_digit_classifier.sv
// Top level of the k-nearest-neighbor digit classifier: input and result
// channels, distance accumulation, control sequencer. Depends on knn_pkg, knn_chain.
//
// Use: the slave channel takes one word per pixel pair; s_tuser[0] marks the
// last pixel of a training image, s_tlast the last pixel of the training set.
// cfg_we/cfg_wdata set k (0 acts as 1, above 16 acts as 16), written while idle.
// Pixel words that end no image sustain one per cycle. At an image end
// the block stalls input: an append writes the next free slot; with a
// full list the maximum search runs the scan token through the 16-cell
// chain. A set end adds a vote scan and a winner search over the classes,
// then the result word is loaded into the output register and the block
// takes input again. If the receiver stalls, that word holds on the master
// channel while the next set streams in; only the following result waits
// for it. Reset empties the list, zeroes the running distance, sets k to 3
// and drops any pending result.
module knn_digit_classifier
    import knn_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [K_W-1:0]     cfg_wdata,      // neighbor_count
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,        // query_pixel, train_pixel, train_label, query_label
    input  logic               s_tlast,        // set_end
    input  logic [0:0]         s_tuser,        // image_end
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,        // predicted_digit, zero fill
    output logic [0:0]         m_tuser         // is_correct
);

    knn_state_t state_reg, state_next;

    logic [K_W-1:0]      k_reg;
    logic [HELD_W-1:0]   eff_k;
    logic [DIST_W-1:0]   dist_sum_reg, dist_sum_next;
    logic [HELD_W-1:0]   held_reg, held_next;
    logic [DIST_W-1:0]   pend_dist_reg, pend_dist_next;
    logic [LABEL_W-1:0]  pend_label_reg, pend_label_next;
    logic [LABEL_W-1:0]  qlabel_reg, qlabel_next;
    logic                pend_set_reg, pend_set_next;
    logic                vote_phase_reg, vote_phase_next;
    logic [CLASS_COUNT-1:0][CNT_W-1:0] votes_reg, votes_next;
    logic [CLS_W-1:0]    cls_reg, cls_next;
    logic [CLS_W-1:0]    win_reg, win_next;
    logic [CNT_W-1:0]    win_cnt_reg, win_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [LABEL_W-1:0]  out_digit_reg, out_digit_next;
    logic                out_ok_reg, out_ok_next;

    logic [PIXEL_W-1:0]  q_pix, t_pix, diff;
    logic [SQ_W-1:0]     sq;
    logic [DIST_W:0]     sum_wide;
    logic [DIST_W-1:0]   acc;
    logic                in_fire;
    logic                is_end;
    logic [LABEL_W-1:0]  pred;

    cell_wr_t  wr;
    scan_tok_t tok_in, tok_out;

    assign q_pix    = s_tdata[7:0];
    assign t_pix    = s_tdata[15:8];
    assign diff     = (q_pix >= t_pix) ? (q_pix - t_pix) : (t_pix - q_pix);
    assign sq       = diff * diff;
    assign sum_wide = {1'b0, dist_sum_reg} + (DIST_W + 1)'(sq);
    assign acc      = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
    assign in_fire  = s_tvalid && s_tready;
    assign is_end   = s_tuser[0] || s_tlast;

    always_comb begin
        if (k_reg == '0) begin
            eff_k = HELD_W'(1);
        end else if (int'(k_reg) > MAX_NEIGHBORS) begin
            eff_k = HELD_W'(MAX_NEIGHBORS);
        end else begin
            eff_k = HELD_W'(k_reg);
        end
    end

    assign pred = (CLS_W >= LABEL_W) ? LABEL_W'(win_reg) : LABEL_W'(win_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM: begin
                if (in_fire && is_end) state_next = ST_PLACE;
            end
            ST_PLACE: begin
                if (held_reg < eff_k && !pend_set_reg) state_next = ST_ACCUM;
                else                                   state_next = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (tok_out.valid) begin
                    if (vote_phase_reg)    state_next = ST_PICK;
                    else if (pend_set_reg) state_next = ST_LAUNCH;
                    else                   state_next = ST_ACCUM;
                end
            end
            ST_PICK: begin
                if (cls_reg == CLS_W'(CLASS_COUNT - 1)) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) state_next = ST_ACCUM;
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_comb begin
        dist_sum_next   = dist_sum_reg;
        held_next       = held_reg;
        pend_dist_next  = pend_dist_reg;
        pend_label_next = pend_label_reg;
        qlabel_next     = qlabel_reg;
        pend_set_next   = pend_set_reg;
        vote_phase_next = vote_phase_reg;
        votes_next      = votes_reg;
        cls_next        = cls_reg;
        win_next        = win_reg;
        win_cnt_next    = win_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_digit_next  = out_digit_reg;
        out_ok_next     = out_ok_reg;
        s_tready        = 1'b0;
        wr              = '0;
        tok_in          = '0;

        if (out_valid_reg && m_tready) out_valid_next = 1'b0;

        case (state_reg)
            ST_ACCUM: begin
                s_tready = 1'b1;
                if (in_fire) begin
                    if (is_end) begin
                        dist_sum_next   = '0;
                        pend_dist_next  = acc;
                        pend_label_next = s_tdata[19:16];
                        qlabel_next     = s_tdata[23:20];
                        pend_set_next   = s_tlast;
                    end else begin
                        dist_sum_next   = acc;
                    end
                end
            end
            ST_PLACE: begin
                if (held_reg < eff_k) begin
                    wr.en           = 1'b1;
                    wr.idx          = held_reg[IDX_W-1:0];
                    wr.distance     = pend_dist_reg;
                    wr.label        = pend_label_reg;
                    held_next       = held_reg + HELD_W'(1);
                    vote_phase_next = 1'b1;
                end else begin
                    vote_phase_next = 1'b0;
                end
            end
            ST_LAUNCH: begin
                tok_in.valid = 1'b1;
            end
            ST_SCAN: begin
                if (tok_out.valid) begin
                    if (vote_phase_reg) begin
                        votes_next   = tok_out.votes;
                        cls_next     = '0;
                        win_next     = '0;
                        win_cnt_next = '0;
                    end else begin
                        if (pend_dist_reg <= tok_out.max_d) begin
                            wr.en       = 1'b1;
                            wr.idx      = tok_out.max_pos;
                            wr.distance = pend_dist_reg;
                            wr.label    = pend_label_reg;
                        end
                        vote_phase_next = 1'b1;
                    end
                end
            end
            ST_PICK: begin
                if (votes_reg[cls_reg] > win_cnt_reg) begin
                    win_next     = cls_reg;
                    win_cnt_next = votes_reg[cls_reg];
                end
                cls_next = cls_reg + CLS_W'(1);
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_digit_next = pred;
                    out_ok_next    = (pred == qlabel_reg);
                    held_next      = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCUM;
            k_reg         <= K_RESET;
            dist_sum_reg  <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_we) k_reg <= cfg_wdata;
            dist_sum_reg  <= dist_sum_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_dist_reg  <= pend_dist_next;
        pend_label_reg <= pend_label_next;
        qlabel_reg     <= qlabel_next;
        pend_set_reg   <= pend_set_next;
        vote_phase_reg <= vote_phase_next;
        votes_reg      <= votes_next;
        cls_reg        <= cls_next;
        win_reg        <= win_next;
        win_cnt_reg    <= win_cnt_next;
        out_digit_reg  <= out_digit_next;
        out_ok_reg     <= out_ok_next;
    end

    knn_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .held    (held_reg),
        .wr      (wr),
        .tok_in  (tok_in),
        .tok_out (tok_out)
    );

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{(8 - LABEL_W){1'b0}}, out_digit_reg};
    assign m_tuser[0] = out_ok_reg;

endmodule

// File: rtl/core/knn_cell.sv
// One neighbor slot: stored distance and label, plus one stage of the scan
// token that searches the maximum and counts votes. Depends on knn_pkg.
module knn_cell
    import knn_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [IDX_W-1:0]   my_idx,
    input  logic [HELD_W-1:0]  held,
    input  cell_wr_t           wr,
    input  scan_tok_t          tok_in,
    output scan_tok_t          tok_out
);

    logic [DIST_W-1:0]  dist_reg;
    logic [LABEL_W-1:0] label_reg;
    scan_tok_t          tok_reg;
    scan_tok_t          tok_next;
    logic               active;

    assign active = tok_in.valid && (HELD_W'(my_idx) < held);

    always_comb begin
        tok_next = tok_in;
        if (active) begin
            if (dist_reg >= tok_in.max_d) begin
                tok_next.max_d   = dist_reg;
                tok_next.max_pos = my_idx;
            end
            for (int c = 0; c < CLASS_COUNT; c++) begin
                if (label_reg == LABEL_W'(c)) begin
                    tok_next.votes[c] = tok_in.votes[c] + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && wr.idx == my_idx) begin
            dist_reg  <= wr.distance;
            label_reg <= wr.label;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: rtl/core/knn_chain.sv
// Row of neighbor cells; the scan token enters cell 0 and leaves the last.
// Depends on knn_pkg and knn_cell.
module knn_chain
    import knn_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [HELD_W-1:0]  held,
    input  cell_wr_t           wr,
    input  scan_tok_t          tok_in,
    output scan_tok_t          tok_out
);

    scan_tok_t tok [MAX_NEIGHBORS+1];

    assign tok[0] = tok_in;

    for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
        knn_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .my_idx  (IDX_W'(i)),
            .held    (held),
            .wr      (wr),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    assign tok_out = tok[MAX_NEIGHBORS];

endmodule
